// ===== design/cst_pkg.sv =====
package cst_pkg;

  localparam int SLOTS    = 64;
  localparam int WAITERS  = 32;

  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int CNT_W    = 16;
  localparam int PID_W    = 8;
  localparam int STAT_W   = 2;

  localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int USED_W   = $clog2(SLOTS + 1);
  localparam int HEAD_W   = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int WCNT_W   = $clog2(WAITERS + 1);
  localparam int WT_DEPTH = SLOTS * WAITERS;
  localparam int WT_AW    = (WT_DEPTH > 1) ? $clog2(WT_DEPTH) : 1;

  localparam logic [ID_W-1:0]  FIRST_AUTO_ID = ID_W'(10);
  localparam logic [CNT_W-1:0] CNT_MAX       = '1;

  localparam int CMDQ_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN     = 3'd0,
    OP_OPEN_ANY = 3'd1,
    OP_CLOSE    = 3'd2,
    OP_WAIT     = 3'd3,
    OP_POST     = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_NOSPACE = 2'd2,
    STAT_QFULL   = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic             bad;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] value;
    logic [PID_W-1:0] pid;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  cnt;
    logic [HEAD_W-1:0] head;
    logic [WCNT_W-1:0] wcnt;
  } slot_ent_t;

  typedef struct packed {
    status_e          status;
    logic [ID_W-1:0]  assigned;
    logic             blocked;
    logic             wake_valid;
    logic [PID_W-1:0] wake_pid;
  } rsp_t;

endpackage

// ===== design/cst_if.sv =====
interface cst_req_if;
  import cst_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ID_W-1:0]   sem_id;
  logic [CNT_W-1:0]  initial_value;
  logic [PID_W-1:0]  caller_pid;

  modport source (output valid, operation, sem_id, initial_value, caller_pid, input ready);
  modport sink   (input valid, operation, sem_id, initial_value, caller_pid, output ready);
endinterface

interface cst_rsp_if;
  import cst_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   assigned_id;
  logic              caller_blocked;
  logic              wake_valid;
  logic [PID_W-1:0]  wake_pid;

  modport source (output valid, status, assigned_id, caller_blocked, wake_valid, wake_pid,
                  input ready);
  modport sink   (input valid, status, assigned_id, caller_blocked, wake_valid, wake_pid,
                  output ready);
endinterface

// ===== design/cst_front.sv =====
module cst_front import cst_pkg::*; (
  cst_req_if.sink  req_i,
  input  logic     push_ready_i,
  output logic     push_valid_o,
  output cmd_t     push_cmd_o
);

  logic op_bad;
  logic id_bad;

  assign op_bad = (req_i.operation > OP_POST);
  assign id_bad = (req_i.operation != OP_OPEN_ANY) && (req_i.sem_id == '0);

  assign req_i.ready  = push_ready_i;
  assign push_valid_o = req_i.valid;

  always_comb begin
    push_cmd_o.op    = op_bad ? OP_OPEN : op_e'(req_i.operation);
    push_cmd_o.bad   = op_bad || id_bad;
    push_cmd_o.id    = req_i.sem_id;
    push_cmd_o.value = req_i.initial_value;
    push_cmd_o.pid   = req_i.caller_pid;
  end

endmodule

// ===== design/cst_cmd_fifo.sv =====
module cst_cmd_fifo import cst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int QAW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCW = $clog2(CMDQ_DEPTH + 1);

  cmd_t           mem_q [CMDQ_DEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;
  logic           push, pop;

  assign push_ready_o = (cnt_q != QCW'(CMDQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : wr_q + QAW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QAW'(CMDQ_DEPTH - 1)) ? '0 : rd_q + QAW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

// ===== design/cst_back.sv =====
module cst_back import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  cst_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PICK, S_EXEC, S_WREAD, S_RESP
  } state_e;

  localparam logic [SLOT_AW:0] SCAN_END = (SLOT_AW + 1)'(SLOTS);

  state_e             state_q;
  cmd_t               cmd_q;
  rsp_t               rsp_q;
  logic [USED_W-1:0]  used_q;
  logic [SLOTS-1:0]   vld_q;
  logic [SLOTS-1:0]   bmp_q;
  logic [SLOT_AW:0]   scan_q;
  logic               chk_vld_q;
  logic [SLOT_AW-1:0] chk_idx_q;
  logic               found_q, free_found_q;
  logic [SLOT_AW-1:0] found_idx_q, free_idx_q;
  slot_ent_t          ent_q;
  logic [SLOT_AW-1:0] pick_q;
  logic [ID_W-1:0]    cand_q;

  slot_ent_t          slot_mem [SLOTS];
  slot_ent_t          slot_rd_q;
  logic [PID_W-1:0]   wt_mem [WT_DEPTH];
  logic [PID_W-1:0]   wt_rd_q;

  logic [SLOT_AW-1:0] slot_raddr, slot_waddr;
  logic               slot_we;
  slot_ent_t          slot_wdata;
  logic               wt_we;
  logic [WT_AW-1:0]   wt_waddr, wt_raddr;

  logic [ID_W-1:0]    ent_id;
  logic [ID_W-1:0]    auto_off;
  logic [WT_AW:0]     wt_base;
  logic [WCNT_W:0]    tail_sum;
  logic [HEAD_W-1:0]  tail, head_next;

  assign ent_id   = vld_q[chk_idx_q] ? slot_rd_q.id : '0;
  assign auto_off = ent_id - FIRST_AUTO_ID;
  assign wt_base  = (WT_AW + 1)'(found_idx_q) * (WT_AW + 1)'(WAITERS);
  assign tail_sum = (WCNT_W + 1)'(ent_q.head) + (WCNT_W + 1)'(ent_q.wcnt);
  assign tail     = (tail_sum >= (WCNT_W + 1)'(WAITERS))
                    ? HEAD_W'(tail_sum - (WCNT_W + 1)'(WAITERS)) : HEAD_W'(tail_sum);
  assign head_next = (ent_q.head == HEAD_W'(WAITERS - 1)) ? '0 : ent_q.head + HEAD_W'(1);
  assign wt_waddr = WT_AW'(wt_base + (WT_AW + 1)'(tail));
  assign wt_raddr = WT_AW'(wt_base + (WT_AW + 1)'(ent_q.head));
  assign slot_raddr = scan_q[SLOT_AW-1:0];

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = found_idx_q;
    slot_wdata = ent_q;
    wt_we      = 1'b0;
    if (state_q == S_EXEC) begin
      unique case (cmd_q.op)
        OP_OPEN, OP_OPEN_ANY: begin
          slot_we         = (cmd_q.op == OP_OPEN_ANY) || !found_q;
          slot_waddr      = free_idx_q;
          slot_wdata.id   = (cmd_q.op == OP_OPEN_ANY) ? cand_q : cmd_q.id;
          slot_wdata.cnt  = cmd_q.value;
          slot_wdata.head = '0;
          slot_wdata.wcnt = '0;
        end
        OP_WAIT: begin
          if (found_q) begin
            if (ent_q.cnt != '0) begin
              slot_we        = 1'b1;
              slot_wdata.cnt = ent_q.cnt - CNT_W'(1);
            end else if (ent_q.wcnt != WCNT_W'(WAITERS)) begin
              slot_we         = 1'b1;
              wt_we           = 1'b1;
              slot_wdata.wcnt = ent_q.wcnt + WCNT_W'(1);
            end
          end
        end
        OP_POST: begin
          if (found_q && ent_q.wcnt == '0 && ent_q.cnt != CNT_MAX) begin
            slot_we        = 1'b1;
            slot_wdata.cnt = ent_q.cnt + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end else if (state_q == S_WREAD) begin
      slot_we         = 1'b1;
      slot_wdata.head = head_next;
      slot_wdata.wcnt = ent_q.wcnt - WCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= cmd_q.pid;
    end
    wt_rd_q <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= '0;
      rsp_q        <= '0;
      used_q       <= '0;
      vld_q        <= '0;
      bmp_q        <= '0;
      scan_q       <= '0;
      chk_vld_q    <= 1'b0;
      chk_idx_q    <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      found_idx_q  <= '0;
      free_idx_q   <= '0;
      ent_q        <= '0;
      pick_q       <= '0;
      cand_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q        <= cmd_i;
            rsp_q        <= '0;
            scan_q       <= '0;
            chk_vld_q    <= 1'b0;
            found_q      <= 1'b0;
            free_found_q <= 1'b0;
            bmp_q        <= '0;
            pick_q       <= '0;
            if (cmd_i.bad) begin
              rsp_q.status <= STAT_INVALID;
              state_q      <= S_RESP;
            end else if ((cmd_i.op == OP_OPEN || cmd_i.op == OP_OPEN_ANY) &&
                         used_q >= USED_W'(SLOTS)) begin
              rsp_q.status <= STAT_NOSPACE;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_q != SCAN_END) begin
            scan_q <= scan_q + (SLOT_AW + 1)'(1);
          end
          chk_vld_q <= (scan_q != SCAN_END);
          chk_idx_q <= scan_q[SLOT_AW-1:0];
          if (chk_vld_q) begin
            if (ent_id == '0 && !free_found_q) begin
              free_found_q <= 1'b1;
              free_idx_q   <= chk_idx_q;
            end
            if (ent_id == cmd_q.id && ent_id != '0 && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= chk_idx_q;
              ent_q       <= slot_rd_q;
            end
            if (ent_id >= FIRST_AUTO_ID && auto_off < ID_W'(SLOTS)) begin
              bmp_q[auto_off[SLOT_AW-1:0]] <= 1'b1;
            end
          end else if (scan_q == SCAN_END) begin
            state_q <= (cmd_q.op == OP_OPEN_ANY) ? S_PICK : S_EXEC;
          end
        end
        S_PICK: begin
          if (!bmp_q[pick_q]) begin
            cand_q  <= FIRST_AUTO_ID + ID_W'(pick_q);
            state_q <= S_EXEC;
          end else begin
            pick_q <= pick_q + SLOT_AW'(1);
          end
        end
        S_EXEC: begin
          state_q <= S_RESP;
          unique case (cmd_q.op)
            OP_OPEN: begin
              if (found_q) begin
                rsp_q.status <= STAT_INVALID;
              end else begin
                vld_q[free_idx_q] <= 1'b1;
                used_q            <= used_q + USED_W'(1);
              end
            end
            OP_OPEN_ANY: begin
              vld_q[free_idx_q] <= 1'b1;
              used_q            <= used_q + USED_W'(1);
              rsp_q.assigned    <= cand_q;
            end
            OP_CLOSE: begin
              if (!found_q) begin
                rsp_q.status <= STAT_INVALID;
              end else begin
                vld_q[found_idx_q] <= 1'b0;
                used_q             <= used_q - USED_W'(1);
              end
            end
            OP_WAIT: begin
              if (!found_q) begin
                rsp_q.status <= STAT_INVALID;
              end else if (ent_q.cnt == '0) begin
                if (ent_q.wcnt == WCNT_W'(WAITERS)) begin
                  rsp_q.status <= STAT_QFULL;
                end else begin
                  rsp_q.blocked <= 1'b1;
                end
              end
            end
            OP_POST: begin
              if (!found_q) begin
                rsp_q.status <= STAT_INVALID;
              end else if (ent_q.wcnt != '0) begin
                state_q <= S_WREAD;
              end
            end
            default: ;
          endcase
        end
        S_WREAD: begin
          rsp_q.wake_valid <= 1'b1;
          rsp_q.wake_pid   <= wt_rd_q;
          state_q          <= S_RESP;
        end
        S_RESP: begin
          if (rsp_o.ready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = (state_q == S_RESP);
  assign rsp_o.status         = rsp_q.status;
  assign rsp_o.assigned_id    = rsp_q.assigned;
  assign rsp_o.caller_blocked = rsp_q.blocked;
  assign rsp_o.wake_valid     = rsp_q.wake_valid;
  assign rsp_o.wake_pid       = rsp_q.wake_pid;

endmodule

// ===== design/counting_semaphore_table_top.sv =====
// Each beat holds the back end until its result beat is taken. The back end scans the slot
// table one entry a cycle through its single read port. Open-any then searches the id bitmap
// for a free auto id. A post that wakes a waiter also reads the waiter memory before it
// responds. A beat rejected up front skips the scan and goes straight to the response.
// A two-entry command queue accepts beats while the table is busy.
// Reset clears the slot valid bits, the used count and all control state at once.
module counting_semaphore_table_top import cst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  cst_req_if.sink   req_i,
  cst_rsp_if.source rsp_o
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  cst_front u_front (
    .req_i        (req_i),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  cst_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  cst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .rsp_o       (rsp_o)
  );

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.wake_valid |-> rsp_o.status == STAT_OK && !rsp_o.caller_blocked)
    else $error("wake reported on a failed or blocking beat");

  a_block_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.caller_blocked |-> rsp_o.status == STAT_OK && rsp_o.assigned_id == '0)
    else $error("blocked caller with a bad status");

  a_assign_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.assigned_id != '0 |->
      rsp_o.status == STAT_OK && rsp_o.assigned_id >= FIRST_AUTO_ID)
    else $error("assigned id out of range or on a failed beat");

endmodule

// ===== tb/sv/counting_semaphore_table_top_tb.sv =====
`timescale 1ns / 100ps

module counting_semaphore_table_top_tb;
  import cst_pkg::*;

  logic clk_i;
  logic rst_ni;

  cst_req_if req_if ();
  cst_rsp_if rsp_if ();

  counting_semaphore_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the semaphore table.
  logic [ID_W-1:0]  sh_ids    [SLOTS];
  logic [CNT_W-1:0] sh_counts [SLOTS];
  logic [PID_W-1:0] sh_waiters[SLOTS][WAITERS];
  int               sh_head   [SLOTS];
  int               sh_wcnt   [SLOTS];
  int               sh_used;

  rsp_t expected_rsps[$];
  int   errors;
  int   beats_sent;
  int   wakes_seen;
  int   blocks_seen;
  int   qfull_seen;
  int   nospace_seen;
  bit   idling_on;

  function automatic int find_slot(int id);
    if (id == 0) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_ids[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic status_e place_id(int id, logic [CNT_W-1:0] val);
    int pos;
    pos = -1;
    if (id == 0) return STAT_INVALID;
    if (sh_used >= SLOTS) return STAT_NOSPACE;
    if (find_slot(id) >= 0) return STAT_INVALID;
    for (int i = 0; i < SLOTS; i++) begin
      if (pos < 0 && sh_ids[i] == '0) pos = i;
    end
    if (pos < 0) return STAT_NOSPACE;
    sh_ids[pos] = ID_W'(id);
    sh_counts[pos] = val;
    sh_head[pos] = 0;
    sh_wcnt[pos] = 0;
    sh_used++;
    return STAT_OK;
  endfunction

  function automatic rsp_t predict_semaphore(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                             logic [CNT_W-1:0] val, logic [PID_W-1:0] pid);
    rsp_t r;
    int   pos;
    int   cand;
    r = '0;
    r.status = STAT_INVALID;
    pos = find_slot(int'(id));
    case (op)
      OP_OPEN: r.status = place_id(int'(id), val);
      OP_OPEN_ANY: begin
        if (sh_used >= SLOTS) begin
          r.status = STAT_NOSPACE;
        end else begin
          cand = int'(FIRST_AUTO_ID);
          while (cand <= 65535 && find_slot(cand) >= 0) cand++;
          r.status = (cand <= 65535) ? place_id(cand, val) : STAT_NOSPACE;
          if (r.status == STAT_OK) r.assigned = ID_W'(cand);
          else r.status = STAT_NOSPACE;
        end
      end
      OP_CLOSE: begin
        if (pos >= 0) begin
          sh_ids[pos] = '0;
          sh_counts[pos] = '0;
          sh_head[pos] = 0;
          sh_wcnt[pos] = 0;
          if (sh_used > 0) sh_used--;
          r.status = STAT_OK;
        end
      end
      OP_WAIT: begin
        if (pos >= 0) begin
          if (sh_counts[pos] > 0) begin
            sh_counts[pos]--;
            r.status = STAT_OK;
          end else if (sh_wcnt[pos] >= WAITERS) begin
            r.status = STAT_QFULL;
          end else begin
            sh_waiters[pos][(sh_head[pos] + sh_wcnt[pos]) % WAITERS] = pid;
            sh_wcnt[pos]++;
            r.blocked = 1'b1;
            r.status = STAT_OK;
          end
        end
      end
      OP_POST: begin
        if (pos >= 0) begin
          if (sh_wcnt[pos] > 0) begin
            r.wake_pid = sh_waiters[pos][sh_head[pos]];
            r.wake_valid = 1'b1;
            sh_head[pos] = (sh_head[pos] + 1) % WAITERS;
            sh_wcnt[pos]--;
          end else if (sh_counts[pos] != CNT_MAX) begin
            sh_counts[pos]++;
          end
          r.status = STAT_OK;
        end
      end
      default: r.status = STAT_INVALID;
    endcase
    return r;
  endfunction

  task automatic send_call(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                           logic [CNT_W-1:0] val, logic [PID_W-1:0] pid);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.sem_id        <= id;
    req_if.initial_value <= val;
    req_if.caller_pid    <= pid;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsps.push_back(predict_semaphore(op, id, val, pid));
    beats_sent++;
  endtask

  task automatic drain_responses();
    int guard;
    guard = 0;
    req_if.valid <= 1'b0;
    while (expected_rsps.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // The sink side: random back-pressure and a check of every beat.
  int stall_left;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected response beat at %0t", $realtime);
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.status !== e.status || rsp_if.assigned_id !== e.assigned ||
              rsp_if.caller_blocked !== e.blocked || rsp_if.wake_valid !== e.wake_valid ||
              rsp_if.wake_pid !== e.wake_pid) begin
            errors++;
            if (errors <= 10)
              $display("Mismatch at %0t: expected st=%0d id=%0d blk=%0b wv=%0b wp=%0d, got st=%0d id=%0d blk=%0b wv=%0b wp=%0d",
                       $realtime, e.status, e.assigned, e.blocked, e.wake_valid, e.wake_pid,
                       rsp_if.status, rsp_if.assigned_id, rsp_if.caller_blocked,
                       rsp_if.wake_valid, rsp_if.wake_pid);
          end
          if (e.wake_valid) wakes_seen++;
          if (e.blocked) blocks_seen++;
          if (e.status == STAT_QFULL) qfull_seen++;
          if (e.status == STAT_NOSPACE) nospace_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 9);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic test_special_cases();
    send_call(OP_OPEN, '0, 16'd5, 8'd1);
    send_call(OP_OPEN, 16'hFFFF, 16'hFFFF, 8'd0);
    send_call(OP_OPEN, 16'hFFFF, 16'd3, 8'd0);
    send_call(OP_POST, 16'hFFFF, '0, 8'd0);
    send_call(OP_WAIT, 16'hFFFF, '0, 8'hFF);
    send_call(OP_WAIT, 16'd1234, '0, 8'd2);
    send_call(OP_POST, 16'd1234, '0, 8'd2);
    send_call(OP_CLOSE, 16'd1234, '0, 8'd2);
    send_call(OP_CLOSE, '0, '0, 8'd0);
    send_call(OP_WAIT, '0, '0, 8'd0);
    send_call(OP_POST, '0, '0, 8'd0);
    send_call(3'd5, 16'd7, 16'd7, 8'd7);
    send_call(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_call(3'd7, 16'hAAAA, 16'h5555, 8'hA5);
    send_call(OP_OPEN_ANY, 16'd99, '0, 8'd0);
    send_call(OP_OPEN_ANY, '0, 16'd1, 8'd0);
    send_call(OP_WAIT, 16'd10, '0, 8'hFF);
    send_call(OP_WAIT, 16'd10, '0, 8'h00);
    send_call(OP_WAIT, 16'd11, '0, 8'h5A);
    send_call(OP_WAIT, 16'd11, '0, 8'hA5);
    send_call(OP_POST, 16'd10, '0, 8'd0);
    send_call(OP_POST, 16'd10, '0, 8'd0);
    send_call(OP_CLOSE, 16'd11, '0, 8'd0);
    send_call(OP_CLOSE, 16'd10, '0, 8'd0);
    send_call(OP_CLOSE, 16'hFFFF, '0, 8'd0);
  endtask

  task automatic test_queue_full();
    send_call(OP_OPEN, 16'd500, '0, 8'd0);
    for (int i = 0; i < WAITERS + 2; i++) begin
      send_call(OP_WAIT, 16'd500, '0, PID_W'($urandom));
    end
    for (int i = 0; i < 5; i++) send_call(OP_POST, 16'd500, '0, 8'd0);
    for (int i = 0; i < 5; i++) send_call(OP_WAIT, 16'd500, '0, PID_W'($urandom));
    send_call(OP_CLOSE, 16'd500, '0, 8'd0);
  endtask

  task automatic test_table_full();
    while (sh_used < SLOTS) send_call(OP_OPEN_ANY, '0, CNT_W'($urandom_range(0, 2)), 8'd0);
    send_call(OP_OPEN, 16'd9, 16'd1, 8'd0);
    send_call(OP_OPEN_ANY, '0, 16'd1, 8'd0);
    send_call(OP_CLOSE, 16'd20, '0, 8'd0);
    send_call(OP_OPEN, 16'd20, 16'd1, 8'd0);
    send_call(OP_OPEN, 16'd30, 16'd1, 8'd0);
    send_call(OP_CLOSE, 16'd15, '0, 8'd0);
    send_call(OP_OPEN_ANY, '0, 16'd0, 8'd0);
    for (int i = 0; i < SLOTS; i++) begin
      if (sh_ids[i] != '0) send_call(OP_CLOSE, sh_ids[i], '0, 8'd0);
    end
  endtask

  task automatic test_random_traffic(int n_items);
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] val;
    int               r;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_responses();
      if (k == n_items - n_items / 6) idling_on = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 12) op = OP_OPEN;
      else if (r < 20) op = OP_OPEN_ANY;
      else if (r < 28) op = OP_CLOSE;
      else if (r < 62) op = OP_WAIT;
      else if (r < 96) op = OP_POST;
      else op = OP_W'($urandom_range(5, 7));
      r = $urandom_range(0, 99);
      if (r < 80) id = ID_W'($urandom_range(1, 24));
      else if (r < 90) id = ID_W'($urandom);
      else if (r < 95) id = 16'hFFFF;
      else id = '0;
      r = $urandom_range(0, 99);
      if (r < 75) val = CNT_W'($urandom_range(0, 3));
      else if (r < 90) val = CNT_W'($urandom);
      else val = CNT_MAX;
      send_call(op, id, val, PID_W'($urandom));
    end
  endtask

  initial begin
    int guard;
    errors       = 0;
    beats_sent   = 0;
    wakes_seen   = 0;
    blocks_seen  = 0;
    qfull_seen   = 0;
    nospace_seen = 0;
    stall_left   = 0;
    idling_on    = 1'b1;
    sh_used      = 0;
    for (int i = 0; i < SLOTS; i++) begin
      sh_ids[i]    = '0;
      sh_counts[i] = '0;
      sh_head[i]   = 0;
      sh_wcnt[i]   = 0;
    end
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.operation     = '0;
    req_if.sem_id        = '0;
    req_if.initial_value = '0;
    req_if.caller_pid    = '0;
    rsp_if.ready         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_queue_full();
    test_table_full();
    test_random_traffic(400);

    drain_responses();
    guard = 0;
    while (guard < 300) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_rsps.size() != 0) errors += expected_rsps.size();

    $display("Sent %0d calls; saw %0d blocked waits, %0d wake-ups, %0d full queues, %0d full tables.",
             beats_sent, blocks_seen, wakes_seen, qfull_seen, nospace_seen);
    $display("Mismatches counted: %0d.", errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cst_pkg.sv
design/cst_if.sv
design/cst_front.sv
design/cst_cmd_fifo.sv
design/cst_back.sv
design/counting_semaphore_table_top.sv
tb/sv/counting_semaphore_table_top_tb.sv
